/* sv/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, codes and scan code tables for the scan code line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    // Number of scan codes covered by the character tables
    localparam int TABLE_ENTRIES = 59;

    // Command queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Scan codes with a special meaning
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam int         SC_BREAK_BIT    = 7;

    // Characters with a special meaning
    localparam logic [6:0] CH_NONE = 7'h00;
    localparam logic [6:0] CH_BS   = 7'h08;
    localparam logic [6:0] CH_LF   = 7'h0A;

    // Result event codes
    localparam logic [1:0] EV_APPEND = 2'd0;
    localparam logic [1:0] EV_ERASE  = 2'd1;
    localparam logic [1:0] EV_DONE   = 2'd2;

    // Queue command kinds
    typedef enum logic [1:0] {
        CMD_APPEND      = 2'd0,
        CMD_ERASE       = 2'd1,
        CMD_DONE        = 2'd2,
        CMD_APPEND_DONE = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] pos;
        logic [6:0] ch;
    } cmd_t;

    function automatic logic [6:0] lower_char(input logic [6:0] idx);
        logic [6:0] c;
        unique case (idx)
            7'd2:    c = 7'h31;
            7'd3:    c = 7'h32;
            7'd4:    c = 7'h33;
            7'd5:    c = 7'h34;
            7'd6:    c = 7'h35;
            7'd7:    c = 7'h36;
            7'd8:    c = 7'h37;
            7'd9:    c = 7'h38;
            7'd10:   c = 7'h39;
            7'd11:   c = 7'h30;
            7'd12:   c = 7'h2D;
            7'd13:   c = 7'h3D;
            7'd14:   c = CH_BS;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h71;
            7'd17:   c = 7'h77;
            7'd18:   c = 7'h65;
            7'd19:   c = 7'h72;
            7'd20:   c = 7'h74;
            7'd21:   c = 7'h79;
            7'd22:   c = 7'h75;
            7'd23:   c = 7'h69;
            7'd24:   c = 7'h6F;
            7'd25:   c = 7'h70;
            7'd26:   c = 7'h5B;
            7'd27:   c = 7'h5D;
            7'd28:   c = CH_LF;
            7'd30:   c = 7'h61;
            7'd31:   c = 7'h73;
            7'd32:   c = 7'h64;
            7'd33:   c = 7'h66;
            7'd34:   c = 7'h67;
            7'd35:   c = 7'h68;
            7'd36:   c = 7'h6A;
            7'd37:   c = 7'h6B;
            7'd38:   c = 7'h6C;
            7'd39:   c = 7'h3B;
            7'd40:   c = 7'h27;
            7'd41:   c = 7'h60;
            7'd43:   c = 7'h5C;
            7'd44:   c = 7'h7A;
            7'd45:   c = 7'h78;
            7'd46:   c = 7'h63;
            7'd47:   c = 7'h76;
            7'd48:   c = 7'h62;
            7'd49:   c = 7'h6E;
            7'd50:   c = 7'h6D;
            7'd51:   c = 7'h2C;
            7'd52:   c = 7'h2E;
            7'd53:   c = 7'h2F;
            7'd55:   c = 7'h2A;
            7'd57:   c = 7'h20;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] upper_char(input logic [6:0] idx);
        logic [6:0] c;
        unique case (idx)
            7'd2:    c = 7'h21;
            7'd3:    c = 7'h40;
            7'd4:    c = 7'h23;
            7'd5:    c = 7'h24;
            7'd6:    c = 7'h25;
            7'd7:    c = 7'h5E;
            7'd8:    c = 7'h26;
            7'd9:    c = 7'h2A;
            7'd10:   c = 7'h28;
            7'd11:   c = 7'h29;
            7'd12:   c = 7'h5F;
            7'd13:   c = 7'h2B;
            7'd14:   c = CH_BS;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h51;
            7'd17:   c = 7'h57;
            7'd18:   c = 7'h45;
            7'd19:   c = 7'h52;
            7'd20:   c = 7'h54;
            7'd21:   c = 7'h59;
            7'd22:   c = 7'h55;
            7'd23:   c = 7'h49;
            7'd24:   c = 7'h4F;
            7'd25:   c = 7'h50;
            7'd26:   c = 7'h7B;
            7'd27:   c = 7'h7D;
            7'd28:   c = CH_LF;
            7'd30:   c = 7'h41;
            7'd31:   c = 7'h53;
            7'd32:   c = 7'h44;
            7'd33:   c = 7'h46;
            7'd34:   c = 7'h47;
            7'd35:   c = 7'h48;
            7'd36:   c = 7'h4A;
            7'd37:   c = 7'h4B;
            7'd38:   c = 7'h4C;
            7'd39:   c = 7'h3A;
            7'd40:   c = 7'h22;
            7'd41:   c = 7'h7E;
            7'd43:   c = 7'h7C;
            7'd44:   c = 7'h5A;
            7'd45:   c = 7'h58;
            7'd46:   c = 7'h43;
            7'd47:   c = 7'h56;
            7'd48:   c = 7'h42;
            7'd49:   c = 7'h4E;
            7'd50:   c = 7'h4D;
            7'd51:   c = 7'h3C;
            7'd52:   c = 7'h3E;
            7'd53:   c = 7'h3F;
            7'd55:   c = 7'h2A;
            7'd57:   c = 7'h20;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/sle_front.sv */
// ----------------------------------------------------------------------------
// sle_front
// Accepts scan codes, tracks shift, caps and line length, and issues
// commands to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [8:0]    cfg_wr_data,
    input  wire logic          accept,
    input  wire logic [7:0]    scan_code,
    output sle_pkg::cmd_t      push_cmd,
    output logic               push
);
    import sle_pkg::*;

    logic [8:0] limit_reg;
    logic       shift_reg, shift_next;
    logic       caps_reg, caps_next;
    logic [7:0] len_reg, len_next;

    logic [7:0] lim_m1;
    logic [8:0] len_inc;
    logic [6:0] ch;
    logic       in_table;

    // Clamp limit to [2, 256] and take the character count that ends a line
    always_comb
    begin
        if (limit_reg < 9'd2)
            lim_m1 = 8'd1;
        else if (limit_reg > 9'd256)
            lim_m1 = 8'd255;
        else
            lim_m1 = 8'(limit_reg - 9'd1);
    end

    assign len_inc  = {1'b0, len_reg} + 9'd1;
    assign in_table = (scan_code < 8'(TABLE_ENTRIES)) && !scan_code[SC_BREAK_BIT];
    assign ch       = (shift_reg ^ caps_reg) ? upper_char(scan_code[6:0])
                                             : lower_char(scan_code[6:0]);

    always_comb
    begin
        shift_next    = shift_reg;
        caps_next     = caps_reg;
        len_next      = len_reg;
        push          = 1'b0;
        push_cmd.kind = CMD_APPEND;
        push_cmd.pos  = len_reg;
        push_cmd.ch   = ch;
        if (accept)
        begin
            if (scan_code == SC_LSHIFT_MAKE || scan_code == SC_RSHIFT_MAKE)
                shift_next = 1'b1;
            else if (scan_code == SC_LSHIFT_BREAK || scan_code == SC_RSHIFT_BREAK)
                shift_next = 1'b0;
            else if (scan_code == SC_CAPS_MAKE)
                caps_next = ~caps_reg;
            else if (in_table && ch != CH_NONE)
            begin
                if (ch == CH_LF)
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_DONE;
                    len_next      = 8'd0;
                    shift_next    = 1'b0;
                    caps_next     = 1'b0;
                end
                else if (ch == CH_BS)
                begin
                    if (len_reg != 8'd0)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_ERASE;
                        push_cmd.pos  = len_reg - 8'd1;
                        len_next      = len_reg - 8'd1;
                    end
                end
                else
                begin
                    push = 1'b1;
                    // Wrap past 255 also lands here: len_inc is 256
                    if (len_inc >= {1'b0, lim_m1})
                    begin
                        push_cmd.kind = CMD_APPEND_DONE;
                        len_next      = 8'd0;
                        shift_next    = 1'b0;
                        caps_next     = 1'b0;
                    end
                    else
                    begin
                        len_next = len_inc[7:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 9'd128;
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
            len_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

/* sv/sle_queue.sv */
// ----------------------------------------------------------------------------
// sle_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sle_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output sle_pkg::cmd_t      head_cmd,
    output logic               empty,
    output logic               full
);
    import sle_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/sle_back.sv */
// ----------------------------------------------------------------------------
// sle_back
// Drains queued commands into the registered result port, splitting an
// append that fills the line into the append and the line-done result.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sle_pkg::cmd_t head_cmd,
    input  wire logic          q_empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         event_res,
    output logic [7:0]         position,
    output logic [6:0]         character,
    output logic               last
);
    import sle_pkg::*;

    logic       valid_reg, valid_next;
    logic       pend_reg, pend_next;
    logic [7:0] pend_pos_reg, pend_pos_next;
    logic [1:0] ev_reg, ev_next;
    logic [7:0] pos_reg, pos_next;
    logic [6:0] ch_reg, ch_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !valid_reg || out_ready;
    assign pop  = load && !pend_reg && !q_empty;

    always_comb
    begin
        valid_next    = valid_reg;
        pend_next     = pend_reg;
        pend_pos_next = pend_pos_reg;
        ev_next       = ev_reg;
        pos_next      = pos_reg;
        ch_next       = ch_reg;
        last_next     = last_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                // Second half of a line-filling append
                valid_next = 1'b1;
                pend_next  = 1'b0;
                ev_next    = EV_DONE;
                pos_next   = pend_pos_reg;
                ch_next    = CH_LF;
                last_next  = 1'b1;
            end
            else if (!q_empty)
            begin
                valid_next = 1'b1;
                pos_next   = head_cmd.pos;
                ch_next    = head_cmd.ch;
                last_next  = 1'b1;
                unique case (head_cmd.kind)
                    CMD_APPEND:      ev_next = EV_APPEND;
                    CMD_ERASE:       ev_next = EV_ERASE;
                    CMD_DONE:        ev_next = EV_DONE;
                    CMD_APPEND_DONE:
                    begin
                        ev_next       = EV_APPEND;
                        last_next     = 1'b0;
                        pend_next     = 1'b1;
                        pend_pos_next = head_cmd.pos + 8'd1;
                    end
                    default:         ev_next = EV_APPEND;
                endcase
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pos_reg <= pend_pos_next;
        ev_reg       <= ev_next;
        pos_reg      <= pos_next;
        ch_reg       <= ch_next;
        last_reg     <= last_next;
    end

    assign out_valid = valid_reg;
    assign event_res = ev_reg;
    assign position  = pos_reg;
    assign character = ch_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

/* sv/scancode_line_editor.sv */
// Path: an accepted scan code is written into the command queue, and the back
//   loads its first result into the output register once the output is free.
// Throughput: one scan code per cycle in while the queue has room, one result
//   per cycle out while out_ready holds; a line-filling code gives two results.
// A four-entry command queue lets the input run on while the output stalls.
// Reset (rst_n low, asynchronous): line limit 128, shift, caps and length cleared.
// ----------------------------------------------------------------------------
// scancode_line_editor
// Turns set-1 keyboard scan codes into line editing events: append, erase
// and line done.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_line_editor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Configuration: line limit, buffer size including terminator
    input  wire logic       cfg_wr_en,
    input  wire logic [8:0] cfg_wr_data,
    // Scan code requests
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] scan_code,
    // Result requests
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      event_res,
    output logic [7:0]      position,
    output logic [6:0]      character,
    output logic            last
);
    import sle_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    logic accept;

    // Take a request whenever the queue has room; codes that produce no
    // result still pass through here to update shift, caps and length.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Front: classify the code, update editor state, issue a command
    sle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .scan_code   (scan_code),
        .push_cmd    (push_cmd),
        .push        (push)
    );

    // Queue: decouple code intake from result delivery
    sle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Back: expand commands into result requests, hold on stall
    sle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .event_res (event_res),
        .position  (position),
        .character (character),
        .last      (last)
    );

endmodule

`default_nettype wire

/* sv/sle_checker.sv */
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the scan code line editor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [1:0] event_res,
    input  wire logic [7:0] position,
    input  wire logic [6:0] character,
    input  wire logic       last
);
    import sle_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(position) && $stable(character) && $stable(last))
        else $error("stalled result changed");

    // Erase echoes backspace and ends the code's results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_ERASE |-> character == CH_BS && last)
        else $error("bad erase result");

    // Line done echoes line feed and ends the code's results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_DONE |-> character == CH_LF && last)
        else $error("bad line done result");

    // Append never carries a control character that means erase or line end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_APPEND |->
            character != CH_NONE && character != CH_BS && character != CH_LF)
        else $error("bad append character");

    // A line-filling append is followed at once by line done at the next index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && event_res == EV_APPEND && !last |=>
            out_valid && event_res == EV_DONE && position == 8'($past(position) + 8'd1))
        else $error("missing line done after full append");

endmodule

bind scancode_line_editor sle_checker u_sle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .position  (position),
    .character (character),
    .last      (last)
);

`default_nettype wire
